// ----- design/uuid_v1_generator_assert.svh -----
// Assertion macros shared by the UUID generator RTL.
`ifndef UUID_V1_GENERATOR_ASSERT_SVH
`define UUID_V1_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UUIDV1_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uuid_v1_generator assertion failed");

// Next-cycle implication, checked outside reset.
`define UUIDV1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uuid_v1_generator assertion failed");

`endif

// ----- design/uuidv1_pkg.sv -----
// Package with constants and controller/datapath types of the UUID generator.
`default_nettype none

package uuidv1_pkg;

    // 141427 days in 100 ns units: Gregorian reform to the Unix epoch.
    localparam logic [63:0] GREG_OFFSET  = 64'h01B2_1DD2_1381_4000;
    localparam logic [15:0] VERSION_BITS = 16'h1000;
    localparam logic [15:0] VARIANT_BIT  = 16'h8000;
    localparam logic [1:0]  NODE_WORDS_LAST = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_FIRST,
        OP_WARM,
        OP_NODE,
        OP_SEQ,
        OP_SUM,
        OP_CMP,
        OP_ADJ,
        OP_APPLY,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic lfsr_zero;
        logic count_zero;
        logic node_last;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/uuidv1_if.sv -----
// Handshake interfaces for the request and response channels.
`default_nettype none

interface uuidv1_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [59:0] now_time;
    logic [15:0] seed_value;

    modport source (output valid, output opcode, output now_time, output seed_value,
                    input ready);
    modport sink   (input valid, input opcode, input now_time, input seed_value,
                    output ready);
endinterface

interface uuidv1_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] stamp_low;
    logic [15:0] stamp_mid;
    logic [15:0] time_high_version;
    logic [15:0] clock_sequence;
    logic [47:0] node_id;
    logic        seed_missing;

    modport source (output valid, output stamp_low, output stamp_mid,
                    output time_high_version, output clock_sequence,
                    output node_id, output seed_missing, input ready);
    modport sink   (input valid, input stamp_low, input stamp_mid,
                    input time_high_version, input clock_sequence,
                    input node_id, input seed_missing, output ready);
endinterface

`default_nettype wire

// ----- design/uuidv1_ctrl.sv -----
// Controller state machine that sequences reseed and generate transactions.
`default_nettype none

module uuidv1_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic                   req_opcode,
    output logic                        req_ready,
    input  wire uuidv1_pkg::dp_status_t status,
    output uuidv1_pkg::dp_op_t          op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_WARM,
        S_NODE,
        S_SEQ,
        S_SUM,
        S_CMP,
        S_ADJ,
        S_APPLY,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = uuidv1_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op = uuidv1_pkg::OP_CAPTURE;
                    if (req_opcode)
                        state_next = S_FIRST;
                    else if (status.lfsr_zero)
                        state_next = S_OUT;
                    else
                        state_next = S_SUM;
                end
            end
            S_FIRST:
            begin
                op         = uuidv1_pkg::OP_FIRST;
                state_next = S_WARM;
            end
            S_WARM:
            begin
                op = uuidv1_pkg::OP_WARM;
                if (status.count_zero)
                    state_next = S_NODE;
            end
            S_NODE:
            begin
                op = uuidv1_pkg::OP_NODE;
                if (status.node_last)
                    state_next = S_SEQ;
            end
            S_SEQ:
            begin
                op         = uuidv1_pkg::OP_SEQ;
                state_next = S_IDLE;
            end
            S_SUM:
            begin
                op         = uuidv1_pkg::OP_SUM;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                op         = uuidv1_pkg::OP_CMP;
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                op         = uuidv1_pkg::OP_ADJ;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                op         = uuidv1_pkg::OP_APPLY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Wait here until the output register can take the result.
                if (!status.out_busy)
                begin
                    op         = uuidv1_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- design/uuidv1_dp.sv -----
// Datapath: LFSR, timestamp arithmetic, generator state and output register.
`default_nettype none

module uuidv1_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire uuidv1_pkg::dp_op_t     op,
    output uuidv1_pkg::dp_status_t      status,
    input  wire logic                   req_opcode,
    input  wire logic [59:0]            req_now_time,
    input  wire logic [15:0]            req_seed_value,
    input  wire logic                   rsp_ready,
    output logic                        rsp_valid,
    output logic [31:0]                 rsp_stamp_low,
    output logic [15:0]                 rsp_stamp_mid,
    output logic [15:0]                 rsp_time_high_version,
    output logic [15:0]                 rsp_clock_sequence,
    output logic [47:0]                 rsp_node_id,
    output logic                        rsp_seed_missing
);

    // Architectural state.
    logic [15:0] lfsr_reg;
    logic [31:0] borrowed_reg;
    logic [63:0] last_reg;
    logic [15:0] cseq_reg;
    logic [47:0] node_reg;

    // Sequencing state.
    logic [2:0]  count_reg;
    logic [1:0]  node_cnt_reg;
    logic        miss_reg;
    logic        gt_reg;
    logic        eq_reg;
    logic        valid_reg;

    // Working values of one transaction.
    logic [63:0] base_reg;
    logic [63:0] tv_reg;
    logic [63:0] room_reg;
    logic [31:0] d_reg;

    // Output payload.
    logic [31:0] tlow_reg;
    logic [15:0] tmid_reg;
    logic [15:0] thigh_reg;
    logic [15:0] oseq_reg;
    logic [47:0] onode_reg;
    logic        omiss_reg;

    logic        feedback;
    logic [15:0] draw_word;

    assign feedback  = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign draw_word = {feedback, lfsr_reg[15:1]};

    assign status.lfsr_zero  = (lfsr_reg == 16'd0);
    assign status.count_zero = (count_reg == 3'd0);
    assign status.node_last  = (node_cnt_reg == uuidv1_pkg::NODE_WORDS_LAST);
    assign status.out_busy   = valid_reg && !rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= '0;
            borrowed_reg <= '0;
            last_reg     <= '0;
            cseq_reg     <= '0;
            node_reg     <= '0;
            count_reg    <= '0;
            node_cnt_reg <= '0;
            miss_reg     <= 1'b0;
            gt_reg       <= 1'b0;
            eq_reg       <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            // A new result may replace one that leaves in the same cycle.
            if (op == uuidv1_pkg::OP_EMIT)
                valid_reg <= 1'b1;
            else if (valid_reg && rsp_ready)
                valid_reg <= 1'b0;
            case (op)
                uuidv1_pkg::OP_CAPTURE:
                begin
                    node_cnt_reg <= '0;
                    miss_reg     <= (lfsr_reg == 16'd0);
                    if (req_opcode)
                        lfsr_reg <= lfsr_reg ^ req_seed_value;
                end
                uuidv1_pkg::OP_FIRST:
                begin
                    lfsr_reg  <= draw_word;
                    count_reg <= draw_word[2:0];
                end
                uuidv1_pkg::OP_WARM:
                begin
                    // Warm-up stops early once the LFSR reads zero.
                    if (count_reg != 3'd0)
                    begin
                        lfsr_reg <= draw_word;
                        if (draw_word == 16'd0)
                            count_reg <= '0;
                        else
                            count_reg <= count_reg - 3'd1;
                    end
                end
                uuidv1_pkg::OP_NODE:
                begin
                    // Shift in from the top so the first word ends lowest.
                    lfsr_reg     <= draw_word;
                    node_reg     <= {draw_word, node_reg[47:16]};
                    node_cnt_reg <= node_cnt_reg + 2'd1;
                end
                uuidv1_pkg::OP_SEQ:
                begin
                    lfsr_reg <= draw_word;
                    cseq_reg <= draw_word;
                end
                uuidv1_pkg::OP_CMP:
                begin
                    gt_reg <= (tv_reg > last_reg);
                    eq_reg <= (tv_reg == last_reg);
                end
                uuidv1_pkg::OP_ADJ:
                begin
                    if (!gt_reg)
                    begin
                        if (eq_reg && (borrowed_reg != 32'hFFFF_FFFF))
                            borrowed_reg <= borrowed_reg + 32'd1;
                        else
                        begin
                            // Time went back or the borrow count wrapped:
                            // restart from the sampled time with a new sequence.
                            lfsr_reg     <= draw_word;
                            cseq_reg     <= draw_word | uuidv1_pkg::VARIANT_BIT;
                            borrowed_reg <= '0;
                        end
                    end
                end
                uuidv1_pkg::OP_APPLY:
                begin
                    if (gt_reg)
                        borrowed_reg <= borrowed_reg - d_reg;
                end
                uuidv1_pkg::OP_EMIT:
                begin
                    if (!miss_reg)
                        last_reg <= tv_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            uuidv1_pkg::OP_CAPTURE:
            begin
                base_reg <= {4'd0, req_now_time} + uuidv1_pkg::GREG_OFFSET;
            end
            uuidv1_pkg::OP_SUM:
            begin
                tv_reg <= base_reg + {32'd0, borrowed_reg};
            end
            uuidv1_pkg::OP_CMP:
            begin
                room_reg <= tv_reg - last_reg - 64'd1;
            end
            uuidv1_pkg::OP_ADJ:
            begin
                if (gt_reg)
                begin
                    if ({32'd0, borrowed_reg} < room_reg)
                        d_reg <= borrowed_reg;
                    else
                        d_reg <= room_reg[31:0];
                end
                else if (eq_reg && (borrowed_reg != 32'hFFFF_FFFF))
                    tv_reg <= tv_reg + 64'd1;
                else
                    tv_reg <= base_reg;
            end
            uuidv1_pkg::OP_APPLY:
            begin
                if (gt_reg)
                    tv_reg <= tv_reg - {32'd0, d_reg};
            end
            uuidv1_pkg::OP_EMIT:
            begin
                omiss_reg <= miss_reg;
                if (miss_reg)
                begin
                    tlow_reg  <= '0;
                    tmid_reg  <= '0;
                    thigh_reg <= '0;
                    oseq_reg  <= '0;
                    onode_reg <= '0;
                end
                else
                begin
                    tlow_reg  <= tv_reg[31:0];
                    tmid_reg  <= tv_reg[47:32];
                    thigh_reg <= tv_reg[63:48] | uuidv1_pkg::VERSION_BITS;
                    oseq_reg  <= cseq_reg;
                    onode_reg <= node_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid             = valid_reg;
    assign rsp_stamp_low         = tlow_reg;
    assign rsp_stamp_mid         = tmid_reg;
    assign rsp_time_high_version = thigh_reg;
    assign rsp_clock_sequence    = oseq_reg;
    assign rsp_node_id           = onode_reg;
    assign rsp_seed_missing      = omiss_reg;

endmodule

`default_nettype wire

// ----- design/uuid_v1_generator.sv -----
// Top level of the time-based UUID generator: controller, datapath, checks.
//
//  channel | role   | carries
//  --------+--------+------------------------------------------------------
//  req_ch  | sink   | opcode, now_time, seed_value
//  rsp_ch  | source | stamp_low, stamp_mid, time_high_version, clock_sequence,
//          |        | node_id, seed_missing
//
// One transaction is worked on at a time; req_ch.ready is high only while idle.
// Generate runs the 64-bit timestamp add, compare and trim, then loads the result
// register (a missing seed skips to it); reseed steps the LFSR and gives no result.
// A stalled rsp_ch holds the controller in its final state; rst_n clears the state
// registers but not the working values or the output payload.
`default_nettype none

`include "uuid_v1_generator_assert.svh"

module uuid_v1_generator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    uuidv1_req_if.sink    req_ch,
    uuidv1_rsp_if.source  rsp_ch
);

    uuidv1_pkg::dp_op_t     op;
    uuidv1_pkg::dp_status_t status;
    logic                   miss_zero;
    logic                   real_uuid;

    uuidv1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_opcode (req_ch.opcode),
        .req_ready  (req_ch.ready),
        .status     (status),
        .op         (op)
    );

    uuidv1_dp u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .op                    (op),
        .status                (status),
        .req_opcode            (req_ch.opcode),
        .req_now_time          (req_ch.now_time),
        .req_seed_value        (req_ch.seed_value),
        .rsp_ready             (rsp_ch.ready),
        .rsp_valid             (rsp_ch.valid),
        .rsp_stamp_low         (rsp_ch.stamp_low),
        .rsp_stamp_mid         (rsp_ch.stamp_mid),
        .rsp_time_high_version (rsp_ch.time_high_version),
        .rsp_clock_sequence    (rsp_ch.clock_sequence),
        .rsp_node_id           (rsp_ch.node_id),
        .rsp_seed_missing      (rsp_ch.seed_missing)
    );

    assign miss_zero = (rsp_ch.stamp_low == 32'd0) && (rsp_ch.stamp_mid == 16'd0) &&
                       (rsp_ch.node_id == 48'd0) && (rsp_ch.clock_sequence == 16'd0) &&
                       (rsp_ch.time_high_version == 16'd0);
    assign real_uuid = rsp_ch.valid && !rsp_ch.seed_missing;

    // A missing seed reports all-zero fields.
    `UUIDV1_ASSERT_NOW(a_miss_zero, clk, rst_n, rsp_ch.valid && rsp_ch.seed_missing, miss_zero)

    // A real UUID always carries the version bits.
    `UUIDV1_ASSERT_NOW(a_version, clk, rst_n, real_uuid, rsp_ch.time_high_version[12])

    // Transactions are worked on one at a time.
    `UUIDV1_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_ch.valid && req_ch.ready, !req_ch.ready)

endmodule

`default_nettype wire
